### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// Used by files that take this header by include; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low.
`define U8SD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("u8sd assertion failed");

// Check that a condition never holds.
`define U8SD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `U8SD_ASSERT(lbl, clk, rst_n, !(cond))

`endif

### rtl/u8sd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; used by u8sd_decode and the top level.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;
  localparam int unsigned CntW = 3;

  // Sequence length codes of the pending sequence
  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThr  = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxCp    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] MinTwo   = 21'h000080;
  localparam logic [CpW-1:0] MinThr   = 21'h000800;
  localparam logic [CpW-1:0] MinFour  = 21'h010000;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [LenW-1:0] exp_len;
    logic [1:0]      held;
    logic [CpW-1:0]  partial;
  } dec_state_t;

  // Results caused by one byte: nrep replacements, then an optional good code point
  typedef struct packed {
    logic [CntW-1:0] nrep;
    logic            good;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            done;
  } run_t;

endpackage

### rtl/u8sd_decode.sv
// Single-byte UTF-8 decode step: next decoder state and the run of results.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_decode (
  input  u8sd_pkg::dec_state_t st_i,
  input  logic [7:0]           byte_i,
  input  logic                 end_i,
  output u8sd_pkg::dec_state_t st_o,
  output u8sd_pkg::run_t       run_o
);

  logic                       pending;
  logic                       is_cont;
  logic [1:0]                 held_inc;
  logic                       complete;
  logic [u8sd_pkg::CpW-1:0]   shifted;
  logic [u8sd_pkg::CpW-1:0]   min_cp;
  logic                       bad;
  logic                       use_fresh;
  logic [u8sd_pkg::LenW-1:0]  lead_len;
  logic [u8sd_pkg::CpW-1:0]   lead_bits;

  assign pending  = (st_i.exp_len != u8sd_pkg::LenNone);
  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign held_inc = st_i.held + 2'd1;
  assign complete = (({1'b0, held_inc} + 3'd1) >= st_i.exp_len);
  assign shifted  = {st_i.partial[14:0], byte_i[5:0]};

  always_comb begin
    unique case (st_i.exp_len)
      u8sd_pkg::LenTwo:  min_cp = u8sd_pkg::MinTwo;
      u8sd_pkg::LenThr:  min_cp = u8sd_pkg::MinThr;
      u8sd_pkg::LenFour: min_cp = u8sd_pkg::MinFour;
      default:           min_cp = '0;
    endcase
  end

  assign bad = (shifted < min_cp) || (shifted > u8sd_pkg::MaxCp) ||
               ((shifted >= u8sd_pkg::SurLo) && (shifted <= u8sd_pkg::SurHi));

  // Classify the byte as a lead
  always_comb begin
    lead_len  = u8sd_pkg::LenNone;
    lead_bits = '0;
    priority if (byte_i[7:5] == 3'b110) begin
      lead_len  = u8sd_pkg::LenTwo;
      lead_bits = {16'd0, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_len  = u8sd_pkg::LenThr;
      lead_bits = {17'd0, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_len  = u8sd_pkg::LenFour;
      lead_bits = {18'd0, byte_i[2:0]};
    end else begin
      lead_len  = u8sd_pkg::LenNone;
      lead_bits = '0;
    end
  end

  assign use_fresh = !pending || !is_cont;

  always_comb begin
    st_o       = st_i;
    run_o      = '0;
    run_o.done = end_i;
    if (pending) begin
      if (is_cont) begin
        st_o.partial = shifted;
        st_o.held    = held_inc;
        if (complete) begin
          st_o = '0;
          if (bad) begin
            run_o.nrep = st_i.exp_len;
          end else begin
            run_o.good = 1'b1;
            run_o.cp   = shifted;
            run_o.len  = st_i.exp_len;
          end
        end else if (end_i) begin
          // flush the held lead and continuations at end of text
          run_o.nrep = 3'd1 + {1'b0, held_inc};
          st_o       = '0;
        end
      end else begin
        // broken sequence: replace what was held, then decode this byte afresh
        run_o.nrep = 3'd1 + {1'b0, st_i.held};
        st_o       = '0;
      end
    end
    if (use_fresh) begin
      if (!byte_i[7]) begin
        run_o.good = 1'b1;
        run_o.cp   = {13'd0, byte_i};
        run_o.len  = u8sd_pkg::LenOne;
      end else if (lead_len != u8sd_pkg::LenNone) begin
        if (end_i) begin
          run_o.nrep = run_o.nrep + 3'd1;
          st_o       = '0;
        end else begin
          st_o.exp_len = lead_len;
          st_o.held    = 2'd0;
          st_o.partial = lead_bits;
        end
      end else begin
        run_o.nrep = run_o.nrep + 3'd1;
      end
    end
  end

endmodule

### rtl/utf8_strict_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result sequencer.
// Depends on u8sd_pkg, u8sd_decode and assert_macros.svh.
`timescale 1ns / 1ps

// Strict UTF-8 stream decoder. Takes one text byte per transfer (tlast marks the
// final byte of the text) and gives one code point per output transfer. Malformed
// input becomes U+FFFD: one per stray or invalid byte, and for a broken, overlong,
// out-of-range or surrogate sequence one per byte it held. A byte that breaks a
// sequence is then decoded afresh. Throughput: one byte per cycle as long as each
// byte yields at most one result and the receiver takes it; a byte that yields
// several results (up to four, only in error cases) holds back the next byte while
// the sequencer hands them out one per cycle as the receiver takes them. A byte
// passes the input register, its results the run register. A byte that only
// extends a pending sequence gives no output transfer. One byte waits in the input
// register while a result stalls; input and output are decoupled by one stage.
module utf8_strict_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] byte_count
  output logic [1:0]  m_axis_tuser,   // [0] replaced, [1] last_in_run
  output logic        m_axis_tlast    // text_done
);

  `include "assert_macros.svh"

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Decoder state and decode step
  u8sd_pkg::dec_state_t st_q, st_d;
  u8sd_pkg::run_t       run_new;

  // Result run register
  logic                        run_vld_q, run_vld_d;
  u8sd_pkg::run_t              run_q;
  logic [u8sd_pkg::CntW-1:0]   total_q;
  logic [u8sd_pkg::CntW-1:0]   emit_q, emit_d;
  logic [u8sd_pkg::CntW-1:0]   total_new;

  logic in_xfer;
  logic out_xfer;
  logic cur_rep;
  logic cur_last;
  logic run_free;
  logic advance;

  u8sd_decode u_decode (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .st_o   (st_d),
    .run_o  (run_new)
  );

  assign total_new = run_new.nrep + {2'b00, run_new.good};

  // Output sequencer: replacements first, then the good code point if any
  assign cur_rep  = (emit_q < run_q.nrep);
  assign cur_last = ((emit_q + 3'd1) == total_q);
  assign out_xfer = run_vld_q && m_axis_tready;

  // The run register frees up when its last result is taken
  assign run_free = !run_vld_q || (out_xfer && cur_last);
  assign advance  = in_vld_q && run_free;

  assign s_axis_tready = !in_vld_q || run_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    run_vld_d = run_vld_q;
    emit_d    = emit_q;
    if (advance) begin
      // a byte that only extends a sequence loads nothing
      run_vld_d = (total_new != '0);
      emit_d    = '0;
    end else if (run_free) begin
      run_vld_d = 1'b0;
      emit_d    = '0;
    end else if (out_xfer) begin
      emit_d = emit_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      run_vld_q <= 1'b0;
      emit_q    <= '0;
      st_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      run_vld_q <= run_vld_d;
      emit_q    <= emit_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
    if (advance) begin
      run_q   <= run_new;
      total_q <= total_new;
    end
  end

  assign m_axis_tvalid      = run_vld_q;
  assign m_axis_tdata[20:0] = cur_rep ? u8sd_pkg::ReplChar : run_q.cp;
  assign m_axis_tdata[23:21] = cur_rep ? u8sd_pkg::LenOne : run_q.len;
  assign m_axis_tuser[0]    = cur_rep;
  assign m_axis_tuser[1]    = cur_last;
  assign m_axis_tlast       = cur_last && run_q.done;

  // Sequencer never runs past the end of its run
  `U8SD_ASSERT(a_emit_in_run, clk_i, rst_ni, run_vld_q |-> (emit_q < total_q))
  // A result that is not a replacement is a valid scalar value
  `U8SD_ASSERT_NEVER(a_good_scalar, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && ((m_axis_tdata[20:0] > u8sd_pkg::MaxCp) || ((m_axis_tdata[20:0] >= u8sd_pkg::SurLo) && (m_axis_tdata[20:0] <= u8sd_pkg::SurHi))))
  // Held continuation count stays below the pending sequence length
  `U8SD_ASSERT(a_held_bound, clk_i, rst_ni, (({1'b0, st_q.held} + 3'd1) < st_q.exp_len) || ((st_q.exp_len == u8sd_pkg::LenNone) && (st_q.held == 2'd0)))
  // No sequence stays pending after the end of the text
  `U8SD_ASSERT(a_flush_at_end, clk_i, rst_ni, (advance && in_end_q) |=> (st_q.exp_len == u8sd_pkg::LenNone))

endmodule

### dv/testbench.sv
// Self-checking testbench for the UTF-8 stream decoder top level.
// Depends on u8sd_pkg and utf8_strict_stream_decoder_core; predicts every result itself.
`timescale 1ns / 1ps

module testbench;
  import u8sd_pkg::*;

  // One decoded result as the output stream carries it
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [CntW-1:0] nbytes;
    logic            repl;
    logic            run_end;
    logic            text_end;
  } cp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  utf8_strict_stream_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  cp_result_t      cp_expected_q[$];
  cp_result_t      step_q[$];
  int              errors;
  int              bytes_sent;
  int              src_idle_pct;
  int              dst_idle_pct;

  // Predictor state: pending sequence length, continuation bytes held, gathered bits
  logic [LenW-1:0] pend_len;
  logic [1:0]      pend_held;
  logic [CpW-1:0]  pend_val;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic add_result(input logic [CpW-1:0] cp, input logic [CntW-1:0] n,
                            input logic r);
    cp_result_t res;
    res = '{cp: cp, nbytes: n, repl: r, run_end: 1'b0, text_end: 1'b0};
    step_q.push_back(res);
  endtask

  // Give one replacement for the lead and one per held continuation, then go idle
  task automatic flush_pending();
    repeat (int'(pend_held) + 1) add_result(ReplChar, 3'd1, 1'b1);
    pend_len  = LenNone;
    pend_held = 2'd0;
    pend_val  = '0;
  endtask

  task automatic start_fresh(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_result({13'd0, b}, 3'd1, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      pend_len  = LenTwo;
      pend_held = 2'd0;
      pend_val  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      pend_len  = LenThr;
      pend_held = 2'd0;
      pend_val  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      pend_len  = LenFour;
      pend_held = 2'd0;
      pend_val  = {18'd0, b[2:0]};
    end else begin
      add_result(ReplChar, 3'd1, 1'b1);
    end
  endtask

  // Work out the results of one accepted byte and queue them
  task automatic predict_code_points(input logic [7:0] b, input logic eot);
    logic [CpW-1:0] min_val;
    cp_result_t     tail;
    step_q.delete();
    if (pend_len != LenNone) begin
      if (b[7:6] == 2'b10) begin
        pend_val  = {pend_val[14:0], b[5:0]};
        pend_held = pend_held + 2'd1;
        if (int'(pend_held) + 1 >= int'(pend_len)) begin
          case (pend_len)
            LenTwo:  min_val = MinTwo;
            LenThr:  min_val = MinThr;
            LenFour: min_val = MinFour;
            default: min_val = '0;
          endcase
          if (pend_val < min_val || pend_val > MaxCp ||
              (pend_val >= SurLo && pend_val <= SurHi)) begin
            repeat (int'(pend_len)) add_result(ReplChar, 3'd1, 1'b1);
          end else begin
            add_result(pend_val, pend_len, 1'b0);
          end
          pend_len  = LenNone;
          pend_held = 2'd0;
          pend_val  = '0;
        end
      end else begin
        flush_pending();
        start_fresh(b);
      end
    end else begin
      start_fresh(b);
    end
    if (eot && pend_len != LenNone) flush_pending();
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.run_end  = 1'b1;
      tail.text_end = eot;
      step_q.push_back(tail);
    end
    foreach (step_q[i]) cp_expected_q.push_back(step_q[i]);
  endtask

  // ---------------------------------------------------------------- drivers

  // Offer one byte, idling at random first; return at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_code_points(b, eot);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send the first nsend bytes of the len-byte encoding of val; tlast falls at random
  task automatic send_seq(input logic [CpW-1:0] val, input int len, input int nsend);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, val[6:0]};
      2: begin
        enc[0] = {3'b110, val[10:6]};
        enc[1] = {2'b10, val[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, val[15:12]};
        enc[1] = {2'b10, val[11:6]};
        enc[2] = {2'b10, val[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, val[20:18]};
        enc[1] = {2'b10, val[17:12]};
        enc[2] = {2'b10, val[11:6]};
        enc[3] = {2'b10, val[5:0]};
      end
    endcase
    for (int i = 0; i < nsend; i++) send_byte(enc[i], $urandom_range(23) == 0);
  endtask

  // Hold the input idle until every expected result has come out
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (cp_expected_q.size() != 0);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    cp_result_t got;
    cp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{cp: m_axis_tdata[20:0], nbytes: m_axis_tdata[23:21], repl: m_axis_tuser[0],
              run_end: m_axis_tuser[1], text_end: m_axis_tlast};
      if (cp_expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cp=%h cnt=%0d repl=%b run_end=%b done=%b",
                 $time, got.cp, got.nbytes, got.repl, got.run_end, got.text_end);
      end else begin
        want = cp_expected_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected cp=%h cnt=%0d repl=%b run_end=%b done=%b",
                   $time, want.cp, want.nbytes, want.repl, want.run_end, want.text_end);
          $display("%0t:          actual   cp=%h cnt=%0d repl=%b run_end=%b done=%b",
                   $time, got.cp, got.nbytes, got.repl, got.run_end, got.text_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // ASCII extremes, stray continuation, invalid high byte
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Good 2-, 3- and 4-byte sequences, the smallest 2-byte and the largest scalar value
  task automatic test_good_sequences();
    send_seq(21'h000080, 2, 2);
    send_seq(21'h0020AC, 3, 3);
    send_seq(MaxCp, 4, 4);
  endtask

  // Overlong via a C1 lead, then a surrogate: one replacement per byte
  task automatic test_bad_values();
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_seq(21'h00D800, 3, 3);
  endtask

  // Broken sequence, flush at end of text, lead byte as the whole text
  task automatic test_breaks_and_flush();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);   // flush three, replace the breaker, end of text
    send_byte(8'hC3, 1'b1);   // lone lead at end of text
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);   // break, then plain ASCII that ends the text
  endtask

  // Mostly well-formed text with random content, plus malformed and noise bytes
  task automatic run_random_text(input int count, input bit drain_midway);
    int target;
    int kind;
    int len;
    logic [CpW-1:0] val;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if (drain_midway && bytes_sent >= target - count / 2) begin
        wait_drain();
        drain_midway = 1'b0;
      end
      kind = $urandom_range(99);
      if (kind < 35) begin
        send_seq(21'($urandom_range(8'h7F)), 1, 1);
      end else if (kind < 50) begin
        send_seq(21'($urandom_range(12'h7FF, 12'h080)), 2, 2);
      end else if (kind < 62) begin
        val = 21'($urandom_range(16'hFFFF, 16'h0800));
        if (val >= SurLo && val <= SurHi) val = val + 21'h000800;
        send_seq(val, 3, 3);
      end else if (kind < 72) begin
        send_seq(21'($urandom_range(21'h10FFFF, 21'h010000)), 4, 4);
      end else if (kind < 77) begin
        // Overlong: a value that fits a shorter form
        len = $urandom_range(4, 2);
        val = (len == 2) ? 21'($urandom_range(8'h7F)) :
              (len == 3) ? 21'($urandom_range(12'h7FF)) : 21'($urandom_range(16'hFFFF));
        send_seq(val, len, len);
      end else if (kind < 81) begin
        send_seq(21'($urandom_range(16'hDFFF, 16'hD800)), 3, 3);
      end else if (kind < 85) begin
        send_seq(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
      end else if (kind < 93) begin
        // Truncated: the next item breaks it or tlast flushes it
        len = $urandom_range(4, 2);
        send_seq(21'($urandom_range(21'h1FFFFF)), len, $urandom_range(len - 1, 1));
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(23) == 0);
      end
    end
  endtask

  task automatic test_random_text();
    src_idle_pct = 30;
    dst_idle_pct = 67;
    run_random_text(118, 1'b1);
    src_idle_pct = 67;
    dst_idle_pct = 30;
    run_random_text(118, 1'b0);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random_text(118, 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);   // close the text
  endtask

  initial begin
    errors        = 0;
    bytes_sent    = 0;
    src_idle_pct  = 30;
    dst_idle_pct  = 67;
    pend_len      = LenNone;
    pend_held     = 2'd0;
    pend_val      = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_bytes();
    test_good_sequences();
    test_bad_values();
    test_breaks_and_flush();
    test_random_text();

    wait_drain();
    repeat (20) @(negedge clk_i);   // catch any stray trailing results
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/u8sd_pkg.sv
rtl/u8sd_decode.sv
rtl/utf8_strict_stream_decoder_core.sv
dv/testbench.sv
